[hw/rtl/pdsel_pkg.sv]
// pdsel_pkg: shared types and constants for the usb pd sink pdo selector
// no dependencies; imported by usb_pd_sink_pdo_selector
`default_nettype none

package pdsel_pkg;

   // default limit on the number of objects looked at per message
   localparam int unsigned MAX_OBJECTS_DEFAULT = 7;

   // configuration register indexes
   localparam logic [1:0] REG_TARGET_MV   = 2'd0;
   localparam logic [1:0] REG_REQUIRED_MA = 2'd1;
   localparam logic [1:0] REG_NOTIFY_MA   = 2'd2;
   localparam logic [1:0] REG_BOOST_MA    = 2'd3;

   // configuration reset values
   localparam logic [14:0] TARGET_MV_RESET   = 15'd5000;
   localparam logic [15:0] REQUIRED_MA_RESET = 16'd3000;
   localparam logic [15:0] NOTIFY_MA_RESET   = 16'd1550;
   localparam logic [15:0] BOOST_MA_RESET    = 16'd1200;

   // supply type field of a power data object (bits 31:30)
   localparam logic [1:0] SEL_FIXED     = 2'd0;
   localparam logic [1:0] SEL_BATTERY   = 2'd1;
   localparam logic [1:0] SEL_VARIABLE  = 2'd2;
   localparam logic [1:0] SEL_AUGMENTED = 2'd3;

   // object kind codes on the result
   localparam logic [1:0] KIND_FIXED    = 2'd0;
   localparam logic [1:0] KIND_VARIABLE = 2'd1;
   localparam logic [1:0] KIND_BATTERY  = 2'd2;
   localparam logic [1:0] KIND_PROG     = 2'd3;

   // decode scale factors
   localparam logic [5:0]  MV_PER_50   = 6'd50;
   localparam logic [6:0]  MV_PER_100  = 7'd100;
   localparam logic [3:0]  MA_PER_10   = 4'd10;
   localparam logic [5:0]  MA_PER_50   = 6'd50;
   localparam logic [27:0] BATT_SCALE  = 28'd250000;

   // divide by ten via reciprocal, exact for values below 10240
   localparam logic [25:0] RECIP_TEN   = 26'd6554;
   localparam logic [15:0] UNITS_LIMIT = 16'd10240;
   localparam logic [9:0]  UNITS_MAX   = 10'd1023;

   // fixed request fields
   localparam logic [9:0]  BATT_POWER_UNITS = 10'd60;
   localparam logic [11:0] PPS_VOLT_UNITS   = 12'd250;
   localparam logic [6:0]  PPS_CURR_UNITS   = 7'd60;

   typedef struct packed {
      logic [31:0] pdo_word;
      logic        last_pdo;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] request_word;
      logic [1:0]  object_kind;
      logic        mismatch;
      logic [15:0] granted_current_ma;
      logic        high_power_flag;
      logic        boost_flag;
   } rsp_payload_type;

endpackage

`default_nettype wire

[hw/rtl/usb_pd_sink_pdo_selector.sv]
// usb pd sink pdo selector: picks a source object and builds the request word
// depends on pdsel_pkg for payload types, register indexes and constants
// a fixed, variable or augmented object goes straight to evaluation; a battery object
// with a nonzero maximum voltage first runs the bit-serial divider (28 quotient steps)
// the last object of a message then builds the result register once that is free
// reset (synchronous, active high) restores the configuration defaults and clears
// the message state and the result valid flag
`default_nettype none

module usb_pd_sink_pdo_selector #(
   parameter int unsigned MAX_OBJECTS = pdsel_pkg::MAX_OBJECTS_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire pdsel_pkg::req_payload_type req_payload,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output pdsel_pkg::rsp_payload_type  rsp_payload,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire [1:0]                   csr_index,
   input  wire [15:0]                  csr_data
);
   import pdsel_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EVAL = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam logic [4:0] DIV_LAST_STEP = 5'd27;
   localparam logic [3:0] MAX_POS       = 4'(MAX_OBJECTS);

   // control state
   logic [1:0]  state_ff, state_in;
   logic [14:0] target_ff, target_in;
   logic [15:0] required_ff, required_in;
   logic [15:0] notify_ff, notify_in;
   logic [15:0] boost_ff, boost_in;
   logic [3:0]  count_ff, count_in;
   logic        matched_ff, matched_in;
   logic [3:0]  match_pos_ff, match_pos_in;
   logic [1:0]  match_kind_ff, match_kind_in;
   logic [15:0] best_ff, best_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;

   // item and divider datapath
   logic [15:0] vmax_ff, vmax_in;
   logic [15:0] vmin_ff, vmin_in;
   logic [15:0] cur_ff, cur_in;
   logic [1:0]  kind_ff, kind_in;
   logic        last_ff, last_in;
   logic [27:0] div_num_ff, div_num_in;
   logic [15:0] div_rem_ff, div_rem_in;
   logic [15:0] div_quo_ff, div_quo_in;
   logic        div_ovf_ff, div_ovf_in;
   rsp_payload_type rsp_ff, rsp_in;

   // decode of the incoming object
   logic [1:0]  dec_sel;
   logic [9:0]  dec_hi10, dec_mid10, dec_lo10;
   logic [15:0] dec_vmax, dec_vmin, dec_cur;
   logic [1:0]  dec_kind;
   logic        dec_div;
   logic [27:0] dec_num;

   // divider step
   logic [16:0] div_trial;
   logic [16:0] div_diff;
   logic        div_bit;
   logic [15:0] div_quo_next;
   logic        div_ovf_next;

   // evaluation and result
   logic        eval_active;
   logic        eval_cover;
   logic        rsp_free;
   logic [25:0] units_prod;
   logic [9:0]  units;
   logic [31:0] rdo;
   logic [1:0]  kind_out;

   logic        req_fire;
   logic        csr_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign req_fire = req_valid && req_ready;
   assign csr_fire = csr_valid && csr_ready;

   // object decode into voltage range and current
   always_comb begin
      dec_sel   = req_payload.pdo_word[31:30];
      dec_hi10  = req_payload.pdo_word[29:20];
      dec_mid10 = req_payload.pdo_word[19:10];
      dec_lo10  = req_payload.pdo_word[9:0];
      dec_vmax  = '0;
      dec_vmin  = '0;
      dec_cur   = '0;
      dec_kind  = KIND_PROG;
      dec_div   = 1'b0;
      dec_num   = 28'(dec_lo10) * BATT_SCALE;
      unique case (dec_sel)
         SEL_FIXED: begin
            dec_vmax = 16'(dec_mid10) * 16'(MV_PER_50);
            dec_vmin = dec_vmax;
            dec_cur  = 16'(dec_lo10) * 16'(MA_PER_10);
            dec_kind = KIND_FIXED;
         end
         SEL_BATTERY: begin
            dec_vmax = 16'(dec_hi10) * 16'(MV_PER_50);
            dec_vmin = 16'(dec_mid10) * 16'(MV_PER_50);
            dec_kind = KIND_BATTERY;
            dec_div  = (dec_vmax != 16'd0);
         end
         SEL_VARIABLE: begin
            dec_vmax = 16'(dec_hi10) * 16'(MV_PER_50);
            dec_vmin = 16'(dec_mid10) * 16'(MV_PER_50);
            dec_cur  = 16'(dec_lo10) * 16'(MA_PER_10);
            dec_kind = KIND_VARIABLE;
         end
         default: begin
            dec_kind = KIND_PROG;
            if (req_payload.pdo_word[29:28] == 2'd0) begin
               dec_vmax = 16'(req_payload.pdo_word[24:17]) * 16'(MV_PER_100);
               dec_vmin = 16'(req_payload.pdo_word[15:8]) * 16'(MV_PER_100);
               dec_cur  = 16'(req_payload.pdo_word[6:0]) * 16'(MA_PER_50);
            end
         end
      endcase
   end

   // one restoring division step per cycle
   always_comb begin
      div_trial    = {div_rem_ff, div_num_ff[27]};
      div_diff     = div_trial - {1'b0, vmax_ff};
      div_bit      = (div_trial >= {1'b0, vmax_ff});
      div_quo_next = {div_quo_ff[14:0], div_bit};
      div_ovf_next = div_ovf_ff || div_quo_ff[15];
   end

   // range check against the target voltage
   assign eval_active = !matched_ff && (count_ff < MAX_POS);
   assign eval_cover  = (vmax_ff >= {1'b0, target_ff}) && (vmin_ff <= {1'b0, target_ff});
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   // request word build from the message state
   always_comb begin
      units_prod = 26'(best_ff[13:0]) * RECIP_TEN;
      units = (best_ff >= UNITS_LIMIT) ? UNITS_MAX : units_prod[25:16];
      kind_out = KIND_FIXED;
      if (!matched_ff) begin
         rdo = (32'd1 << 28) | (32'd1 << 26) | (32'd1 << 24)
             | (32'(units) << 10) | 32'(units);
      end else if (match_kind_ff == KIND_PROG) begin
         rdo = (32'(match_pos_ff) << 28) | (32'd1 << 24)
             | (32'(PPS_VOLT_UNITS) << 9) | 32'(PPS_CURR_UNITS);
         kind_out = KIND_PROG;
      end else if (match_kind_ff == KIND_BATTERY) begin
         rdo = (32'(match_pos_ff) << 28) | (32'd1 << 24)
             | (32'(BATT_POWER_UNITS) << 10) | 32'(BATT_POWER_UNITS);
         kind_out = KIND_BATTERY;
      end else begin
         rdo = (32'(match_pos_ff) << 28) | (32'd1 << 24)
             | (32'(units) << 10) | 32'(units);
         kind_out = match_kind_ff;
      end
   end

   // next state
   always_comb begin
      state_in      = state_ff;
      target_in     = target_ff;
      required_in   = required_ff;
      notify_in     = notify_ff;
      boost_in      = boost_ff;
      count_in      = count_ff;
      matched_in    = matched_ff;
      match_pos_in  = match_pos_ff;
      match_kind_in = match_kind_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff;
      div_cnt_in    = div_cnt_ff;
      vmax_in       = vmax_ff;
      vmin_in       = vmin_ff;
      cur_in        = cur_ff;
      kind_in       = kind_ff;
      last_in       = last_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_ovf_in    = div_ovf_ff;
      rsp_in        = rsp_ff;

      // configuration writes
      if (csr_fire) begin
         unique case (csr_index)
            REG_TARGET_MV:   target_in   = csr_data[14:0];
            REG_REQUIRED_MA: required_in = csr_data;
            REG_NOTIFY_MA:   notify_in   = csr_data;
            default:         boost_in    = csr_data;
         endcase
      end

      // result register drains
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               vmax_in    = dec_vmax;
               vmin_in    = dec_vmin;
               cur_in     = dec_cur;
               kind_in    = dec_kind;
               last_in    = req_payload.last_pdo;
               div_num_in = dec_num;
               div_rem_in = '0;
               div_quo_in = '0;
               div_ovf_in = 1'b0;
               div_cnt_in = '0;
               state_in   = dec_div ? ST_DIV : ST_EVAL;
            end
         end
         ST_DIV: begin
            div_num_in = {div_num_ff[26:0], 1'b0};
            div_rem_in = div_bit ? div_diff[15:0] : div_trial[15:0];
            div_quo_in = div_quo_next;
            div_ovf_in = div_ovf_next;
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == DIV_LAST_STEP) begin
               cur_in   = div_ovf_next ? 16'hFFFF : div_quo_next;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_active && eval_cover) begin
               if (cur_ff >= required_ff) begin
                  matched_in    = 1'b1;
                  match_pos_in  = count_ff + 4'd1;
                  match_kind_in = kind_ff;
                  best_in       = cur_ff;
               end else if (cur_ff > best_ff) begin
                  best_in = cur_ff;
               end
            end
            if (count_ff != 4'hF) begin
               count_in = count_ff + 4'd1;
            end
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         default: begin
            if (rsp_free) begin
               rsp_in.request_word       = rdo;
               rsp_in.object_kind        = kind_out;
               rsp_in.mismatch           = !matched_ff;
               rsp_in.granted_current_ma = best_ff;
               rsp_in.high_power_flag    = (best_ff > notify_ff);
               rsp_in.boost_flag         = (best_ff > boost_ff);
               rsp_valid_in  = 1'b1;
               count_in      = '0;
               matched_in    = 1'b0;
               match_pos_in  = '0;
               match_kind_in = KIND_FIXED;
               best_in       = '0;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         target_ff     <= TARGET_MV_RESET;
         required_ff   <= REQUIRED_MA_RESET;
         notify_ff     <= NOTIFY_MA_RESET;
         boost_ff      <= BOOST_MA_RESET;
         count_ff      <= '0;
         matched_ff    <= 1'b0;
         match_pos_ff  <= '0;
         match_kind_ff <= KIND_FIXED;
         best_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         target_ff     <= target_in;
         required_ff   <= required_in;
         notify_ff     <= notify_in;
         boost_ff      <= boost_in;
         count_ff      <= count_in;
         matched_ff    <= matched_in;
         match_pos_ff  <= match_pos_in;
         match_kind_ff <= match_kind_in;
         best_ff       <= best_in;
         rsp_valid_ff  <= rsp_valid_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      vmax_ff    <= vmax_in;
      vmin_ff    <= vmin_in;
      cur_ff     <= cur_in;
      kind_ff    <= kind_in;
      last_ff    <= last_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_ovf_ff <= div_ovf_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire
